/* rtl/core/bpw_pkg.sv */
// ----------------------------------------------------------------------------
// bpw_pkg - shared definitions for the blend pixel writer
// Field widths, command and register codes, scaling constants and the
// write request that the sequencer hands to the pixel store.
// ----------------------------------------------------------------------------
package bpw_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 13;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 24;
  localparam int ALPHA_W   = 9;
  localparam int TAG_W     = 8;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_COLOR  = 2'd2;

  localparam logic [DIM_W-1:0]   DIM_RESET   = 9'd256;
  localparam logic [COLOR_W-1:0] CLEAR_RESET = 24'h0A96FA;
  localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 9'd256;

  // |pos| * dim is at most 4096 * 511
  localparam int PROD_W = 21;
  localparam int Q_W    = 12;

  // x: divide by 1920 = 128 * 15
  localparam int SHX     = 7;
  localparam int XP_W    = PROD_W - SHX;
  localparam int DIVX    = 15;
  localparam int RECIP_X = (1 << XP_W) / DIVX;
  localparam int XR_W    = XP_W + 2;

  // y: divide by 1020 = 4 * 255
  localparam int SHY     = 2;
  localparam int YP_W    = PROD_W - SHY;
  localparam int DIVY    = 255;
  localparam int RECIP_Y = (1 << YP_W) / DIVY;
  localparam int YR_W    = YP_W + 1;

  // shared multiplier operands
  localparam int MUL_A_W = YP_W;
  localparam int MUL_B_W = 13;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic               we_color;
    logic               we_tag;
    logic [COLOR_W-1:0] color;
    logic [TAG_W-1:0]   tag;
  } mem_wr_t;

endpackage

/* rtl/core/blend_pixel_writer_with_collision_tags_unit.sv */
// ----------------------------------------------------------------------------
// blend_pixel_writer_with_collision_tags_unit - blending pixel writer
// Alpha-blends pixels into a colour buffer kept beside a collision tag
// buffer, with coordinate scaling, tag lookup, full clear and scan-out read.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid in_ready cmd pos_x pos_y red_in        | in
//           | green_in blue_in alpha tag_in                   |
//   out     | out_valid out_ready tag_out color_out in_bounds | out
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data          | in
//
// One shared multiplier is stepped through scale, reciprocal divide, address
// and three channel blends for put pixel; get tag skips the blends, read
// colour skips the scaling, and an access out of bounds skips the address,
// read and blends before the result beat is offered.
// Clear sweeps all MAX_WIDTH*MAX_HEIGHT entries of the stores one entry a
// cycle, and offers its result through S_DONE after the sweep.
// After reset the same sweep fills the stores with in_ready low; cfg beats
// are taken at any time.
// A stalled result waits in the output register and the next item can be
// accepted meanwhile; a second result holds in_ready low until it moves out.
// ----------------------------------------------------------------------------
module blend_pixel_writer_with_collision_tags_unit
  import bpw_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [CH_W-1:0]         red_in,
  input  logic [CH_W-1:0]         green_in,
  input  logic [CH_W-1:0]         blue_in,
  input  logic [ALPHA_W-1:0]      alpha,
  input  logic [TAG_W-1:0]        tag_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TAG_W-1:0]        tag_out,
  output logic [COLOR_W-1:0]      color_out,
  output logic                    in_bounds,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [COLOR_W-1:0]      cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [COLOR_W-1:0] clear_color;
  logic [DIM_W-1:0]   eff_width;
  logic [DIM_W-1:0]   eff_height;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic [ADDR_W-1:0]  mem_addr;
  mem_wr_t            mem_wr;
  logic [COLOR_W-1:0] rd_color;
  logic [TAG_W-1:0]   rd_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
      clear_color  <= CLEAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_CLEAR_COLOR:  clear_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  // oversized frame acts as the buffer's own size
  assign eff_width  = (int'(frame_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : frame_width;
  assign eff_height = (int'(frame_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : frame_height;

  bpw_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .alpha      (alpha),
    .tag_in     (tag_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tag_out    (tag_out),
    .color_out  (color_out),
    .in_bounds  (in_bounds),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .clear_color(clear_color),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_prod   (mul_prod),
    .mem_addr   (mem_addr),
    .mem_wr     (mem_wr),
    .rd_color   (rd_color),
    .rd_tag     (rd_tag)
  );

  bpw_mul u_mul (
    .clk (clk),
    .op_a(mul_a),
    .op_b(mul_b),
    .prod(mul_prod)
  );

  bpw_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .addr    (mem_addr),
    .wr      (mem_wr),
    .rd_color(rd_color),
    .rd_tag  (rd_tag)
  );

  // the fill sweep holds off requests right after reset
  a_reset_sweep: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // one request in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // out of bounds gives an all-zero result
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_bounds) |-> (tag_out == '0 && color_out == '0))
    else $error("nonzero result for out-of-bounds access");

  // a colour result never carries a tag
  a_color_no_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && color_out != '0) |-> (tag_out == '0))
    else $error("tag and colour both returned");

endmodule

/* rtl/core/bpw_mul.sv */
// ----------------------------------------------------------------------------
// bpw_mul - shared multiplier
// Unsigned multiply with the product registered; used by every step of
// scaling, addressing and blending.
// ----------------------------------------------------------------------------
module bpw_mul
  import bpw_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] op_a,
  input  logic [MUL_B_W-1:0] op_b,
  output logic [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

endmodule

/* rtl/core/bpw_store.sv */
// ----------------------------------------------------------------------------
// bpw_store - colour and collision tag memories
// One write port and one registered read port, both at the same address.
// ----------------------------------------------------------------------------
module bpw_store
  import bpw_pkg::*;
#(
  parameter  int DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic [ADDR_W-1:0]  addr,
  input  mem_wr_t            wr,
  output logic [COLOR_W-1:0] rd_color,
  output logic [TAG_W-1:0]   rd_tag
);

  logic [COLOR_W-1:0] color_mem [DEPTH];
  logic [TAG_W-1:0]   tag_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_color) begin
      color_mem[addr] <= wr.color;
    end
    rd_color <= color_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (wr.we_tag) begin
      tag_mem[addr] <= wr.tag;
    end
    rd_tag <= tag_mem[addr];
  end

endmodule

/* rtl/core/bpw_seq.sv */
// ----------------------------------------------------------------------------
// bpw_seq - request sequencer
// Steps put and get requests through scaling, bounds check, address and read,
// puts also through blend and write, on the shared multiplier; read colour
// skips the scaling; runs the fill and clear sweeps; holds the result register.
// ----------------------------------------------------------------------------
module bpw_seq
  import bpw_pkg::*;
#(
  parameter  int DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic [CH_W-1:0]          red_in,
  input  logic [CH_W-1:0]          green_in,
  input  logic [CH_W-1:0]          blue_in,
  input  logic [ALPHA_W-1:0]       alpha,
  input  logic [TAG_W-1:0]         tag_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TAG_W-1:0]         tag_out,
  output logic [COLOR_W-1:0]       color_out,
  output logic                     in_bounds,
  input  logic [DIM_W-1:0]         eff_width,
  input  logic [DIM_W-1:0]         eff_height,
  input  logic [COLOR_W-1:0]       clear_color,
  output logic [MUL_A_W-1:0]       mul_a,
  output logic [MUL_B_W-1:0]       mul_b,
  input  logic [MUL_P_W-1:0]       mul_prod,
  output logic [ADDR_W-1:0]        mem_addr,
  output mem_wr_t                  mem_wr,
  input  logic [COLOR_W-1:0]       rd_color,
  input  logic [TAG_W-1:0]         rd_tag
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MX   = 4'd2;
  localparam logic [3:0] S_RX   = 4'd3;
  localparam logic [3:0] S_MY   = 4'd4;
  localparam logic [3:0] S_RY   = 4'd5;
  localparam logic [3:0] S_CY   = 4'd6;
  localparam logic [3:0] S_ADR  = 4'd7;
  localparam logic [3:0] S_AD2  = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_BR   = 4'd10;
  localparam logic [3:0] S_BG   = 4'd11;
  localparam logic [3:0] S_BB   = 4'd12;
  localparam logic [3:0] S_WR   = 4'd13;
  localparam logic [3:0] S_CLR  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [3:0]         state;
  logic [CMD_W-1:0]   cmd_r;
  logic               neg_x;
  logic               neg_y;
  logic [POS_W-1:0]   mag_x;
  logic [POS_W-1:0]   mag_y;
  logic [COLOR_W-1:0] new_color;
  logic [ALPHA_W-1:0] alpha_r;
  logic [TAG_W-1:0]   tag_r;
  logic [YP_W-1:0]    pf;
  logic [Q_W-1:0]     qx;
  logic [DIM_W-1:0]   sx;
  logic [DIM_W-1:0]   sy;
  logic [ADDR_W-1:0]  addr;
  logic [CH_W-1:0]    blend_r;
  logic [CH_W-1:0]    blend_g;
  logic [COLOR_W-1:0] fill_color;
  logic [TAG_W-1:0]   res_tag;
  logic [COLOR_W-1:0] res_color;
  logic               res_inb;

  logic [POS_W-1:0]   px_u;
  logic [POS_W-1:0]   py_u;
  logic               read_inb;
  logic [Q_W-1:0]     q0x;
  logic [XR_W-1:0]    rem_x;
  logic [Q_W-1:0]     qx_fix;
  logic [Q_W-1:0]     q0y;
  logic [YR_W-1:0]    rem_y;
  logic [Q_W-1:0]     qy_fix;
  logic               inb_x;
  logic               inb_y;
  logic [CH_W-1:0]    iss_old;
  logic [CH_W-1:0]    iss_new;
  logic [CH_W-1:0]    iss_mag;
  logic [CH_W-1:0]    fin_old;
  logic [CH_W-1:0]    fin_new;
  logic [CH_W-1:0]    fin_q;
  logic [CH_W-1:0]    blend_res;
  logic               accept;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mem_addr = addr;

  // unsigned views of the virtual coordinates; a magnitude of 4096 still fits unsigned
  assign px_u = pos_x;
  assign py_u = pos_y;
  assign read_inb = !px_u[POS_W-1] && !py_u[POS_W-1] &&
                    (px_u < POS_W'(eff_width)) && (py_u < POS_W'(eff_height));

  // reciprocal quotient is at most one low, one compare fixes it
  assign q0x    = mul_prod[XP_W +: Q_W];
  assign rem_x  = XR_W'(pf[XP_W-1:0]) - XR_W'(q0x) * XR_W'(DIVX);
  assign qx_fix = q0x + Q_W'(rem_x >= XR_W'(DIVX));

  assign q0y    = mul_prod[YP_W +: Q_W];
  assign rem_y  = YR_W'(pf) - YR_W'(q0y) * YR_W'(DIVY);
  assign qy_fix = q0y + Q_W'(rem_y >= YR_W'(DIVY));

  // negative side is in bounds only when it truncates to zero
  assign inb_x = (qx < Q_W'(eff_width)) && (!neg_x || (qx == '0));
  assign inb_y = (qy_fix < Q_W'(eff_height)) && (!neg_y || (qy_fix == '0));

  // channel whose product is issued this cycle
  always_comb begin
    unique case (state)
      S_BG: begin
        iss_old = rd_color[CH_W +: CH_W];
        iss_new = new_color[CH_W +: CH_W];
      end
      S_BB: begin
        iss_old = rd_color[0 +: CH_W];
        iss_new = new_color[0 +: CH_W];
      end
      default: begin
        iss_old = rd_color[2*CH_W +: CH_W];
        iss_new = new_color[2*CH_W +: CH_W];
      end
    endcase
  end

  assign iss_mag = (iss_new >= iss_old) ? (iss_new - iss_old) : (iss_old - iss_new);

  // channel whose product returns this cycle
  always_comb begin
    unique case (state)
      S_BB: begin
        fin_old = rd_color[CH_W +: CH_W];
        fin_new = new_color[CH_W +: CH_W];
      end
      S_WR: begin
        fin_old = rd_color[0 +: CH_W];
        fin_new = new_color[0 +: CH_W];
      end
      default: begin
        fin_old = rd_color[2*CH_W +: CH_W];
        fin_new = new_color[2*CH_W +: CH_W];
      end
    endcase
  end

  assign fin_q     = mul_prod[CH_W +: CH_W];
  assign blend_res = (fin_new >= fin_old) ? (fin_old + fin_q) : (fin_old - fin_q);

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_MX: begin
        mul_a = MUL_A_W'(mag_x);
        mul_b = MUL_B_W'(eff_width);
      end
      S_RX: begin
        mul_a = MUL_A_W'(mul_prod[PROD_W-1:SHX]);
        mul_b = MUL_B_W'(RECIP_X);
      end
      S_MY: begin
        mul_a = MUL_A_W'(mag_y);
        mul_b = MUL_B_W'(eff_height);
      end
      S_RY: begin
        mul_a = MUL_A_W'(mul_prod[PROD_W-1:SHY]);
        mul_b = MUL_B_W'(RECIP_Y);
      end
      S_ADR: begin
        mul_a = MUL_A_W'(sy);
        mul_b = MUL_B_W'(eff_width);
      end
      S_BR, S_BG, S_BB: begin
        mul_a = MUL_A_W'(iss_mag);
        mul_b = MUL_B_W'(alpha_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mem_wr = '0;
    if (state == S_INIT || state == S_CLR) begin
      mem_wr.we_color = 1'b1;
      mem_wr.we_tag   = 1'b1;
      mem_wr.color    = fill_color;
    end else if (state == S_WR) begin
      mem_wr.we_color = 1'b1;
      mem_wr.we_tag   = (tag_r != '0) && (alpha_r != '0);
      mem_wr.color    = {blend_r, blend_g, blend_res};
      mem_wr.tag      = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      addr       <= '0;
      fill_color <= CLEAR_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT, S_CLR: begin
          if (addr == LAST_ADDR) begin
            addr  <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            addr <= addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= cmd;
            neg_x     <= px_u[POS_W-1];
            neg_y     <= py_u[POS_W-1];
            mag_x     <= px_u[POS_W-1] ? (~px_u + POS_W'(1)) : px_u;
            mag_y     <= py_u[POS_W-1] ? (~py_u + POS_W'(1)) : py_u;
            new_color <= {red_in, green_in, blue_in};
            alpha_r   <= (alpha > ALPHA_FULL) ? ALPHA_FULL : alpha;
            tag_r     <= tag_in;
            res_tag   <= '0;
            res_color <= '0;
            priority case (cmd)
              CMD_CLEAR: begin
                fill_color <= clear_color;
                addr       <= '0;
                res_inb    <= 1'b0;
                state      <= S_CLR;
              end
              CMD_READ: begin
                sx      <= px_u[DIM_W-1:0];
                sy      <= py_u[DIM_W-1:0];
                res_inb <= read_inb;
                state   <= read_inb ? S_ADR : S_DONE;
              end
              default: begin
                res_inb <= 1'b0;
                state   <= S_MX;
              end
            endcase
          end
        end
        S_MX: state <= S_RX;
        S_RX: begin
          pf    <= YP_W'(mul_prod[PROD_W-1:SHX]);
          state <= S_MY;
        end
        S_MY: begin
          qx    <= qx_fix;
          state <= S_RY;
        end
        S_RY: begin
          pf    <= mul_prod[PROD_W-1:SHY];
          state <= S_CY;
        end
        S_CY: begin
          sx      <= neg_x ? '0 : qx[DIM_W-1:0];
          sy      <= neg_y ? '0 : qy_fix[DIM_W-1:0];
          res_inb <= inb_x && inb_y;
          state   <= (inb_x && inb_y) ? S_ADR : S_DONE;
        end
        S_ADR: state <= S_AD2;
        S_AD2: begin
          addr  <= mul_prod[ADDR_W-1:0] + ADDR_W'(sx);
          state <= S_RD;
        end
        S_RD: state <= S_BR;
        S_BR: begin
          priority case (cmd_r)
            CMD_READ: begin
              res_color <= rd_color;
              state     <= S_DONE;
            end
            CMD_GET: begin
              res_tag <= rd_tag;
              state   <= S_DONE;
            end
            default: begin
              res_tag <= rd_tag;
              state   <= S_BG;
            end
          endcase
        end
        S_BG: begin
          blend_r <= blend_res;
          state   <= S_BB;
        end
        S_BB: begin
          blend_g <= blend_res;
          state   <= S_WR;
        end
        S_WR: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            tag_out   <= res_tag;
            color_out <= res_color;
            in_bounds <= res_inb;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule
